### hdl/tsd_pkg.sv
// Shared types, constants and decode functions for the two-digit seven-segment driver.
`default_nettype none

package tsd_pkg;

   // Command queue between front and back
   localparam int CmdqDepth = 2;
   localparam int CMDQ_AW   = $clog2(CmdqDepth);
   localparam int CMDQ_CW   = $clog2(CmdqDepth + 1);

   // Pin actions
   localparam logic [2:0] ACT_SHIFT   = 3'd0;
   localparam logic [2:0] ACT_LATCH_L = 3'd1;
   localparam logic [2:0] ACT_LATCH_R = 3'd2;
   localparam logic [2:0] ACT_ENABLE  = 3'd3;
   localparam logic [2:0] ACT_BLANK   = 3'd4;

   // Request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   // A draw: 8 shifts, latch, 8 shifts, latch, enable
   localparam int DrawLen     = 19;
   localparam int STEP_W      = $clog2(DrawLen);
   localparam logic [STEP_W-1:0] STEP_LATCH_L = STEP_W'(8);
   localparam logic [STEP_W-1:0] STEP_LATCH_R = STEP_W'(17);
   localparam logic [STEP_W-1:0] STEP_ENABLE  = STEP_W'(DrawLen - 1);
   localparam logic [STEP_W-1:0] STEP_R_TOP   = STEP_W'(16);

   // floor(x / 100) for 16-bit x: (x * 83887) >> 23
   localparam logic [16:0] DIV100_RECIP = 17'd83887;
   localparam int          DIV100_SHIFT = 23;

   localparam logic [15:0] COUNT_RESET = 16'd200;
   localparam logic [15:0] ANIM_FRAMES = 16'd8;
   localparam logic [7:0]  CHAR_SPACE  = 8'h20;

   typedef struct packed {
      logic       blank;
      logic [7:0] left_seg;
      logic [7:0] right_seg;
   } cmd_type;

   function automatic logic [7:0] hex_seg(input logic [3:0] idx);
      logic [7:0] seg;
      case (idx)
         4'h0: seg = 8'h7E;
         4'h1: seg = 8'h30;
         4'h2: seg = 8'h6D;
         4'h3: seg = 8'h79;
         4'h4: seg = 8'h33;
         4'h5: seg = 8'h5B;
         4'h6: seg = 8'h5F;
         4'h7: seg = 8'h70;
         4'h8: seg = 8'h7F;
         4'h9: seg = 8'h7B;
         4'hA: seg = 8'h77;
         4'hB: seg = 8'h1F;
         4'hC: seg = 8'h4E;
         4'hD: seg = 8'h3D;
         4'hE: seg = 8'h4F;
         4'hF: seg = 8'h47;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

   // Hex digit characters to segments; anything else is blank
   function automatic logic [7:0] decode_char(input logic [7:0] c);
      logic [7:0] seg;
      logic [7:0] off;
      seg = 8'h00;
      off = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         off = c - 8'h30;
         seg = hex_seg(off[3:0]);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         off = c - 8'h37;
         seg = hex_seg(off[3:0]);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         off = c - 8'h57;
         seg = hex_seg(off[3:0]);
      end
      return seg;
   endfunction

   function automatic logic [7:0] anim_left(input logic [2:0] f);
      logic [7:0] seg;
      case (f)
         3'd0: seg = 8'h01;
         3'd1: seg = 8'h20;
         3'd2: seg = 8'h40;
         3'd3: seg = 8'h02;
         3'd4: seg = 8'h01;
         3'd5: seg = 8'h10;
         3'd6: seg = 8'h08;
         3'd7: seg = 8'h04;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

   function automatic logic [7:0] anim_right(input logic [2:0] f);
      logic [7:0] seg;
      case (f)
         3'd0: seg = 8'h01;
         3'd1: seg = 8'h02;
         3'd2: seg = 8'h40;
         3'd3: seg = 8'h20;
         3'd4: seg = 8'h01;
         3'd5: seg = 8'h04;
         3'd6: seg = 8'h08;
         3'd7: seg = 8'h10;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

   // x mod 5: 16 = 1 (mod 5), so sum the nibbles, then fold down
   function automatic logic [2:0] mod5_16(input logic [15:0] x);
      logic [5:0] s;
      s = 6'(x[3:0]) + 6'(x[7:4]) + 6'(x[11:8]) + 6'(x[15:12]);
      if (s >= 6'd40) s = s - 6'd40;
      if (s >= 6'd20) s = s - 6'd20;
      if (s >= 6'd10) s = s - 6'd10;
      if (s >= 6'd5)  s = s - 6'd5;
      return s[2:0];
   endfunction

endpackage

`default_nettype wire

### hdl/tsd_front.sv
// Front end: accepts requests, keeps display state, derives commands from them.
`default_nettype none

module tsd_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   output logic                 full,
   input  wire logic            req_type,
   input  wire logic [7:0]      req_left_char,
   input  wire logic [7:0]      req_right_char,
   input  wire logic            req_blink_enable,
   input  wire logic [15:0]     req_timeout_ms,
   input  wire logic            cmdq_full,
   output logic                 cmd_push,
   output tsd_pkg::cmd_type     cmd
);

   logic [7:0]  stored_left_ff,  stored_left_in;
   logic [7:0]  stored_right_ff, stored_right_in;
   logic        blink_mode_ff,   blink_mode_in;
   logic [15:0] countdown_ff,    countdown_in;
   logic        show_next_ff,    show_next_in;

   logic        accept;
   logic        is_write;
   logic [32:0] prod;
   logic [15:0] quot;
   logic [15:0] dec;
   logic        in_anim;
   logic        blink_hit;
   logic [7:0]  char_l, char_r;

   assign full     = cmdq_full;
   assign accept   = push && !cmdq_full;
   assign is_write = (req_type == tsd_pkg::REQ_WRITE);

   always_comb begin
      prod      = 33'(req_timeout_ms) * 33'(tsd_pkg::DIV100_RECIP);
      quot      = 16'(prod >> tsd_pkg::DIV100_SHIFT);
      dec       = countdown_ff - 16'd1;
      in_anim   = (dec < tsd_pkg::ANIM_FRAMES);
      blink_hit = blink_mode_ff && (tsd_pkg::mod5_16(dec) == 3'd0);
      char_l    = is_write ? req_left_char  : stored_left_ff;
      char_r    = is_write ? req_right_char : stored_right_ff;

      cmd.blank     = 1'b0;
      cmd.left_seg  = tsd_pkg::decode_char(char_l);
      cmd.right_seg = tsd_pkg::decode_char(char_r);
      cmd_push      = 1'b0;

      stored_left_in  = stored_left_ff;
      stored_right_in = stored_right_ff;
      blink_mode_in   = blink_mode_ff;
      countdown_in    = countdown_ff;
      show_next_in    = show_next_ff;

      if (accept) begin
         if (is_write) begin
            stored_left_in  = req_left_char;
            stored_right_in = req_right_char;
            blink_mode_in   = req_blink_enable;
            countdown_in    = quot;
            cmd_push        = 1'b1;
         end else if (in_anim) begin
            cmd.left_seg  = tsd_pkg::anim_left(dec[2:0]);
            cmd.right_seg = tsd_pkg::anim_right(dec[2:0]);
            cmd_push      = 1'b1;
            countdown_in  = (dec == 16'd0) ? tsd_pkg::ANIM_FRAMES : dec;
         end else begin
            countdown_in = dec;
            if (blink_hit) begin
               cmd_push     = 1'b1;
               cmd.blank    = !show_next_ff;
               show_next_in = !show_next_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_left_ff  <= tsd_pkg::CHAR_SPACE;
         stored_right_ff <= tsd_pkg::CHAR_SPACE;
         blink_mode_ff   <= 1'b0;
         countdown_ff    <= tsd_pkg::COUNT_RESET;
         show_next_ff    <= 1'b1;
      end else begin
         stored_left_ff  <= stored_left_in;
         stored_right_ff <= stored_right_in;
         blink_mode_ff   <= blink_mode_in;
         countdown_ff    <= countdown_in;
         show_next_ff    <= show_next_in;
      end
   end

endmodule

`default_nettype wire

### hdl/tsd_cmdq.sv
// Short command queue between the front end and the pin sequencer.
`default_nettype none

module tsd_cmdq (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire tsd_pkg::cmd_type wr_data,
   output logic                  q_full,
   input  wire logic             rd_en,
   output tsd_pkg::cmd_type      rd_data,
   output logic                  q_empty
);

   tsd_pkg::cmd_type entry_ff [tsd_pkg::CmdqDepth];

   logic [tsd_pkg::CMDQ_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tsd_pkg::CMDQ_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tsd_pkg::CMDQ_CW-1:0] count_ff,  count_in;

   assign q_full  = (count_ff == tsd_pkg::CMDQ_CW'(tsd_pkg::CmdqDepth));
   assign q_empty = (count_ff == '0);
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) count_in = count_ff + tsd_pkg::CMDQ_CW'(1);
      if (rd_en && !wr_en) count_in = count_ff - tsd_pkg::CMDQ_CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) entry_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

`default_nettype wire

### hdl/tsd_back.sv
// Back end: one pin action of a command per unstalled cycle into an output register.
`default_nettype none

module tsd_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire tsd_pkg::cmd_type    head,
   input  wire logic                q_empty,
   output logic                     q_pop,
   output logic                     empty,
   input  wire logic                pop,
   output logic [2:0]               rsp_action,
   output logic                     rsp_serial_level,
   output logic                     rsp_last
);

   logic [tsd_pkg::STEP_W-1:0] step_ff, step_in;
   logic                       valid_ff, valid_in;
   logic [2:0]                 action_ff, action_in;
   logic                       level_ff, level_in;
   logic                       last_ff, last_in;

   logic                       advance;
   logic                       go;
   logic                       final_step;
   logic [tsd_pkg::STEP_W-1:0] r_off;
   logic [2:0]                 r_idx;

   assign advance    = !valid_ff || pop;
   assign go         = advance && !q_empty;
   assign final_step = head.blank || (step_ff == tsd_pkg::STEP_ENABLE);
   assign q_pop      = go && final_step;

   assign empty            = !valid_ff;
   assign rsp_action       = action_ff;
   assign rsp_serial_level = level_ff;
   assign rsp_last         = last_ff;

   always_comb begin
      r_off = tsd_pkg::STEP_R_TOP - step_ff;
      r_idx = r_off[2:0];

      // segment data goes out MSB first, inverted
      action_in = tsd_pkg::ACT_SHIFT;
      level_in  = 1'b0;
      last_in   = final_step;
      if (head.blank) begin
         action_in = tsd_pkg::ACT_BLANK;
      end else if (step_ff < tsd_pkg::STEP_LATCH_L) begin
         level_in = !head.left_seg[~step_ff[2:0]];
      end else if (step_ff == tsd_pkg::STEP_LATCH_L) begin
         action_in = tsd_pkg::ACT_LATCH_L;
      end else if (step_ff < tsd_pkg::STEP_LATCH_R) begin
         level_in = !head.right_seg[r_idx];
      end else if (step_ff == tsd_pkg::STEP_LATCH_R) begin
         action_in = tsd_pkg::ACT_LATCH_R;
      end else begin
         action_in = tsd_pkg::ACT_ENABLE;
      end

      step_in = step_ff;
      if (go) step_in = final_step ? '0 : step_ff + tsd_pkg::STEP_W'(1);

      valid_in = valid_ff;
      if (go)       valid_in = 1'b1;
      else if (pop) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         action_ff <= action_in;
         level_ff  <= level_in;
         last_ff   <= last_in;
      end
   end

endmodule

`default_nettype wire

### hdl/two_digit_seven_segment_driver.sv
// Top level of the two-digit seven-segment driver: front end, command queue, pin sequencer.
// The first pin action of a request is registered in the queue entry, then in the output register.
// One pin action per cycle while pop keeps up; a draw is 19 pin actions, a blank one, set by the
// back-end step counter. Requests keep flowing while the 2-entry command queue has room.
// Reset (synchronous, active high): chars = space, blink off, countdown 200,
// blink shows next, queue and output register empty.
`default_nettype none

module two_digit_seven_segment_driver (
   input  wire logic        clock,
   input  wire logic        reset,
   // request side
   input  wire logic        push,
   output logic             full,
   input  wire logic        req_type,
   input  wire logic [7:0]  req_left_char,
   input  wire logic [7:0]  req_right_char,
   input  wire logic        req_blink_enable,
   input  wire logic [15:0] req_timeout_ms,
   // result side
   output logic             empty,
   input  wire logic        pop,
   output logic [2:0]       rsp_action,
   output logic             rsp_serial_level,
   output logic             rsp_last
);

   // Front end -> queue
   tsd_pkg::cmd_type cmd_wr;
   logic             cmd_push;
   logic             cmdq_full;

   // Queue -> back end
   tsd_pkg::cmd_type cmd_head;
   logic             cmdq_empty;
   logic             cmdq_pop;

   // Front: holds the chars, blink flag and countdown. A write or tick is classified
   // here in its transfer cycle; ticks that do nothing push no command.
   tsd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_type         (req_type),
      .req_left_char    (req_left_char),
      .req_right_char   (req_right_char),
      .req_blink_enable (req_blink_enable),
      .req_timeout_ms   (req_timeout_ms),
      .cmdq_full        (cmdq_full),
      .cmd_push         (cmd_push),
      .cmd              (cmd_wr)
   );

   // Decouples the front from the pin sequencer so each side can stall on its own.
   tsd_cmdq u_cmdq (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_push),
      .wr_data (cmd_wr),
      .q_full  (cmdq_full),
      .rd_en   (cmdq_pop),
      .rd_data (cmd_head),
      .q_empty (cmdq_empty)
   );

   // Back: walks the head command, releasing it after its final action.
   tsd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (cmd_head),
      .q_empty          (cmdq_empty),
      .q_pop            (cmdq_pop),
      .empty            (empty),
      .pop              (pop),
      .rsp_action       (rsp_action),
      .rsp_serial_level (rsp_serial_level),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

### hdl/tsd_chk.sv
// Port-level checker for the two-digit seven-segment driver, bound to the top level.
`default_nettype none

module tsd_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        push,
   input wire logic        full,
   input wire logic        req_type,
   input wire logic [7:0]  req_left_char,
   input wire logic [7:0]  req_right_char,
   input wire logic        req_blink_enable,
   input wire logic [15:0] req_timeout_ms,
   input wire logic        empty,
   input wire logic        pop,
   input wire logic [2:0]  rsp_action,
   input wire logic        rsp_serial_level,
   input wire logic        rsp_last
);

   // nothing to show right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result shown right after reset");

   a_action_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_action == tsd_pkg::ACT_SHIFT || rsp_action == tsd_pkg::ACT_LATCH_L ||
                  rsp_action == tsd_pkg::ACT_LATCH_R || rsp_action == tsd_pkg::ACT_ENABLE ||
                  rsp_action == tsd_pkg::ACT_BLANK))
      else $error("undefined pin action");

   a_level_shift_only: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_action != tsd_pkg::ACT_SHIFT) |-> !rsp_serial_level)
      else $error("serial level high outside a shift");

   a_terminal_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_action == tsd_pkg::ACT_ENABLE || rsp_action == tsd_pkg::ACT_BLANK))
      |-> rsp_last)
      else $error("enable or blank not marked last");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_action) && $stable(rsp_serial_level)
                             && $stable(rsp_last)))
      else $error("stalled result changed");

endmodule

bind two_digit_seven_segment_driver tsd_chk u_tsd_chk (.*);

`default_nettype wire
